### rtl/itaf_pkg.sv
// Types, character codes and helpers shared by the integer-to-ASCII formatter.
package itaf_pkg;

  // Format selector codes
  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX8 = 2'd2;
  localparam logic [1:0] OP_HEX16 = 2'd3;

  // Suffix selector codes (code three means no suffix)
  localparam logic [1:0] SFX_NONE = 2'd0;
  localparam logic [1:0] SFX_SPACE = 2'd1;
  localparam logic [1:0] SFX_CR = 2'd2;

  // ASCII characters
  localparam logic [6:0] CHR_ZERO = 7'h30;
  localparam logic [6:0] CHR_A = 7'h41;
  localparam logic [6:0] CHR_MINUS = 7'h2D;
  localparam logic [6:0] CHR_SPACE = 7'h20;
  localparam logic [6:0] CHR_CR = 7'h0D;

  // Hex formatting
  localparam logic [15:0] HEX_BYTE_MASK = 16'h00FF;
  localparam int unsigned HEX_BYTE_DIGITS = 2;
  localparam int unsigned HEX_HALF_DIGITS = 4;
  localparam logic [3:0] NIB_NINE = 4'h9;
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'h5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'h3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT,
    ST_SUFFIX
  } fmt_state_t;

  // One nibble as an uppercase hex character; decimal digits map the same way
  function automatic logic [6:0] nib_to_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib > NIB_NINE) begin
      c = CHR_A + 7'(nib - 4'd10);
    end else begin
      c = CHR_ZERO + 7'(nib);
    end
    return c;
  endfunction

endpackage

### rtl/itaf_if.sv
// Valid/ready channel interfaces for the formatter's input and result items.
interface itaf_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [VALUE_WIDTH-1:0] value;
  logic [1:0]             suffix;

  modport source (output valid, output op, output value, output suffix, input ready);
  modport sink (input valid, input op, input value, input suffix, output ready);
endinterface

interface itaf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink (input valid, input char_out, input last, output ready);
endinterface

### rtl/itaf_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module itaf_dabble import itaf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NDIG = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] mag,
  output logic                   busy,
  output logic [NDIG*4-1:0]      bcd
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [NDIG*4-1:0]      bcd_r, bcd_nxt;
  logic [NDIG*4-1:0]      adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   run_r, run_nxt;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= BCD_ADJ_LIMIT) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + BCD_ADJ_ADD;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // Load on start, then shift one magnitude bit into the BCD word per cycle
  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      mag_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_WIDTH);
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {adj[NDIG*4-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy = run_r;
  assign bcd  = bcd_r;

endmodule

### rtl/integer_to_ascii_formatter_top.sv
// Integer-to-ASCII formatter: one number in, one character per result item out.
// Decimal formats first pass through the bit-serial BCD converter, then drop each suppressed
// leading zero and emit one character at a time; hex starts emitting digits at once.
// The block takes one number at a time: a new number is accepted only once the sequencer is
// back in idle after the last character of the previous one.
// Reset: synchronous active-low rst_n returns the sequencer to idle and empties the output.
module integer_to_ascii_formatter_top import itaf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  itaf_in_if.sink   in_ch,
  itaf_out_if.source out_ch
);

  // Decimal digits needed for VALUE_WIDTH bits, and the digit register size
  localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned NDREG = (NDIG > 4) ? NDIG : 4;
  localparam int unsigned CW = $clog2(NDREG + 1);
  localparam int unsigned IW = $clog2(NDREG);

  fmt_state_t state_r, state_nxt;

  logic [NDREG-1:0][3:0] dig_r, dig_nxt;
  logic [CW-1:0]         dcnt_r, dcnt_nxt;
  logic [CW-1:0]         dsel;
  logic [3:0]            cur;
  logic                  lead_r, lead_nxt;
  logic                  neg_r, neg_nxt;
  logic                  sgn_r, sgn_nxt;
  logic [1:0]            sfx_r, sfx_nxt;
  logic                  has_sfx;

  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  can_emit;

  logic                   conv_start;
  logic                   conv_busy;
  logic [NDIG*4-1:0]      conv_bcd;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   in_neg;
  logic [15:0]            hex16;

  // Sign detection and magnitude of the incoming number
  assign in_neg = (in_ch.op == OP_SDEC) && in_ch.value[VALUE_WIDTH-1];
  assign mag    = in_neg ? (~in_ch.value + 1'b1) : in_ch.value;
  assign hex16  = (in_ch.op == OP_HEX8) ? (16'(in_ch.value) & HEX_BYTE_MASK)
                                        : 16'(in_ch.value);

  itaf_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NDIG(NDIG)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .mag   (mag),
    .busy  (conv_busy),
    .bcd   (conv_bcd)
  );

  assign dsel     = dcnt_r - 1'b1;
  assign cur      = dig_r[dsel[IW-1:0]];
  assign has_sfx  = (sfx_r == SFX_SPACE) || (sfx_r == SFX_CR);
  assign can_emit = !out_valid_r || out_ch.ready;

  // Sequencer: convert decimal numbers, then sign (signed decimal only), digits and suffix one character at a time
  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    dcnt_nxt      = dcnt_r;
    lead_nxt      = lead_r;
    neg_nxt       = neg_r;
    sgn_nxt       = sgn_r;
    sfx_nxt       = sfx_r;
    conv_start    = 1'b0;
    in_ch.ready   = (state_r == ST_IDLE);
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          sfx_nxt = in_ch.suffix;
          neg_nxt = in_neg;
          sgn_nxt = (in_ch.op == OP_SDEC);
          if (in_ch.op == OP_HEX8 || in_ch.op == OP_HEX16) begin
            dig_nxt   = (NDREG*4)'(hex16);
            dcnt_nxt  = (in_ch.op == OP_HEX8) ? CW'(HEX_BYTE_DIGITS) : CW'(HEX_HALF_DIGITS);
            lead_nxt  = 1'b0;
            state_nxt = ST_DIGIT;
          end else begin
            conv_start = 1'b1;
            dcnt_nxt   = CW'(NDIG);
            lead_nxt   = 1'b1;
            state_nxt  = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (!conv_busy) begin
          dig_nxt   = (NDREG*4)'(conv_bcd);
          state_nxt = sgn_r ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = neg_r ? CHR_MINUS : CHR_SPACE;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (lead_r && (cur == 4'd0) && (dcnt_r > CW'(1))) begin
          // leading zero: drop it without an output slot
          dcnt_nxt = dcnt_r - 1'b1;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = nib_to_char(cur);
          out_last_nxt  = (dcnt_r == CW'(1)) && !has_sfx;
          lead_nxt      = 1'b0;
          if (dcnt_r == CW'(1)) begin
            state_nxt = has_sfx ? ST_SUFFIX : ST_IDLE;
          end else begin
            dcnt_nxt = dcnt_r - 1'b1;
          end
        end
      end
      ST_SUFFIX: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = (sfx_r == SFX_CR) ? CHR_CR : CHR_SPACE;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      lead_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dcnt_r      <= dcnt_nxt;
      lead_r      <= lead_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    neg_r      <= neg_nxt;
    sgn_r      <= sgn_nxt;
    sfx_r      <= sfx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;

endmodule

### sim/itaf_checker.sv
// Checker for the integer-to-ASCII formatter: predicts each number's characters and compares.
`timescale 1ns / 1ps

module itaf_checker import itaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  itaf_in_if          in_ch,
  itaf_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_item_t;

  // Characters still owed by the block, oldest first
  char_item_t expected_chars[$];
  // Characters of the number being formatted
  logic [6:0] line_chars[$];

  // Decimal digits of a magnitude, most significant first, zero prints as one digit
  function automatic void push_decimal(input logic [31:0] mag);
    logic [6:0] digits[$];
    logic [31:0] rest;
    rest = mag;
    do begin
      digits.push_front(CHR_ZERO + 7'(rest % 32'd10));
      rest = rest / 32'd10;
    end while (rest != 0);
    foreach (digits[i]) line_chars.push_back(digits[i]);
  endfunction

  // Uppercase hex digits of the low nibbles, most significant first
  function automatic void push_hex(input logic [31:0] bits, input int ndig);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = 4'((bits >> (4 * i)) & 32'hF);
      if (nib < 4'd10) begin
        line_chars.push_back(CHR_ZERO + 7'(nib));
      end else begin
        line_chars.push_back(CHR_A + 7'(nib - 4'd10));
      end
    end
  endfunction

  // Work out every character one number turns into and queue them
  function automatic void format_chars(input logic [1:0] op, input logic [31:0] value,
                                       input logic [1:0] suffix);
    char_item_t item;
    line_chars.delete();
    case (op)
      OP_UDEC: begin
        push_decimal(value);
      end
      OP_SDEC: begin
        if (value[31]) begin
          line_chars.push_back(CHR_MINUS);
          push_decimal(~value + 32'd1);
        end else begin
          line_chars.push_back(CHR_SPACE);
          push_decimal(value);
        end
      end
      OP_HEX8: begin
        push_hex(value, HEX_BYTE_DIGITS);
      end
      default: begin
        push_hex(value, HEX_HALF_DIGITS);
      end
    endcase
    // suffix code three falls through as no suffix
    if (suffix == SFX_SPACE) begin
      line_chars.push_back(CHR_SPACE);
    end else if (suffix == SFX_CR) begin
      line_chars.push_back(CHR_CR);
    end
    foreach (line_chars[i]) begin
      item.code = line_chars[i];
      item.last = (i == line_chars.size() - 1);
      expected_chars.push_back(item);
    end
  endfunction

  // Watch both channels; queue on input items, compare on result items
  always @(posedge clk) begin
    char_item_t want;
    if (!rst_n) begin
      expected_chars.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        format_chars(in_ch.op, in_ch.value, in_ch.suffix);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected item, expected none, got char %h last %b",
                   $realtime, out_ch.char_out, out_ch.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.char_out !== want.code || out_ch.last !== want.last) begin
            $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                     $realtime, want.code, want.last, out_ch.char_out, out_ch.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= $unsigned(expected_chars.size());
    end
  end

endmodule

### sim/tb_top.sv
// Top of the formatter testbench: clock, reset, number stimulus, result pacing and verdict.
`timescale 1ns / 1ps

module tb_top import itaf_pkg::*;;

  localparam int unsigned RANDOM_NUMBERS = 460;
  localparam int unsigned MAX_WAIT = 14;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_cycles;
  bit          no_idle;

  itaf_in_if #(.VALUE_WIDTH(32)) in_ch ();
  itaf_out_if out_ch ();

  integer_to_ascii_formatter_top #(.VALUE_WIDTH(32)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  itaf_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one number and hold it until the block takes it
  task automatic send_number(input logic [1:0] op, input logic [31:0] value,
                             input logic [1:0] suffix);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.value  <= value;
    in_ch.suffix <= suffix;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mix of full-range, short, digit-boundary and sign-boundary numbers
  function automatic logic [31:0] random_value();
    logic [31:0] pow10[10];
    logic [31:0] v;
    pow10 = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
              32'd10000000, 32'd100000000, 32'd1000000000};
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 99);
      1: v = pow10[$urandom_range(0, 9)] + 32'($urandom_range(0, 2)) - 32'd1;
      2: v = 32'h8000_0000 + 32'($urandom_range(0, 2)) - 32'd1;
      3: v = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      4: v = $urandom() >> $urandom_range(0, 31);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Result side: random stall before each item, bursts with none
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [1:0] op;
    logic [1:0] suffix;
    no_idle       = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_UDEC;
    in_ch.value  <= '0;
    in_ch.suffix <= SFX_NONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every format and suffix, most negative value
    send_number(OP_UDEC, 32'd0, SFX_NONE);
    send_number(OP_UDEC, 32'hFFFF_FFFF, SFX_SPACE);
    send_number(OP_UDEC, 32'd1000000000, SFX_CR);
    send_number(OP_UDEC, 32'd999999999, 2'd3);
    send_number(OP_UDEC, 32'd9, SFX_NONE);
    send_number(OP_UDEC, 32'd10, SFX_SPACE);
    send_number(OP_SDEC, 32'd0, SFX_NONE);
    send_number(OP_SDEC, 32'h7FFF_FFFF, SFX_CR);
    send_number(OP_SDEC, 32'h8000_0000, SFX_SPACE);
    send_number(OP_SDEC, 32'h8000_0001, SFX_NONE);
    send_number(OP_SDEC, 32'hFFFF_FFFF, 2'd3);
    send_number(OP_SDEC, 32'd1, SFX_CR);
    send_number(OP_HEX8, 32'h0000_0000, SFX_NONE);
    send_number(OP_HEX8, 32'h0000_00FF, SFX_SPACE);
    send_number(OP_HEX8, 32'hDEAD_BEA5, SFX_CR);
    send_number(OP_HEX8, 32'h1234_5678, 2'd3);
    send_number(OP_HEX16, 32'h0000_0000, SFX_NONE);
    send_number(OP_HEX16, 32'h0000_FFFF, SFX_SPACE);
    send_number(OP_HEX16, 32'hABCD_1234, SFX_CR);
    send_number(OP_HEX16, 32'h5A5A_C3F0, 2'd3);
    send_number(OP_UDEC, 32'hFFFF_FFFF, SFX_NONE);

    // Random numbers, with bursts of back-to-back items on both sides
    for (int unsigned n = 0; n < RANDOM_NUMBERS; n++) begin
      if (n % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      op     = 2'($urandom_range(0, 3));
      suffix = 2'($urandom_range(0, 3));
      send_number(op, random_value(), suffix);
    end
    in_ch.valid <= 1'b0;
    no_idle      = 1'b0;

    // Let the checker count the last number, drain, then allow time for any stray result
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/itaf_pkg.sv
rtl/itaf_if.sv
rtl/itaf_dabble.sv
rtl/integer_to_ascii_formatter_top.sv
sim/itaf_checker.sv
sim/tb_top.sv
